>>> rtl/core/rc4ks_pkg.sv
`timescale 1ns / 1ps

package rc4ks_pkg;

    localparam int BYTE_W        = 8;
    localparam int BOX_DEPTH     = 256;
    localparam int KEY_DEPTH_DEF = 256;

    typedef enum logic [1:0] {
        MODE_KEY   = 2'd0,
        MODE_DATA  = 2'd1,
        MODE_RESET = 2'd2
    } t_mode;

    typedef struct packed {
        logic key_wr;
        logic clr;
        logic data_cap;
        logic idx_clr;
        logic init_wr;
        logic sw_rd_i;
        logic sw_rd_c;
        logic sw_wr_i;
        logic sw_wr_c;
        logic set_ready;
        logic rd_j;
        logic rd_ab;
        logic rd_mask;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic key_empty;
        logic box_ready;
        logic idx_last;
        logic out_free;
    } t_dp_stat;

endpackage

>>> rtl/core/rc4ks_ctrl.sv
`timescale 1ns / 1ps

module rc4ks_ctrl
    import rc4ks_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic [1:0] i_mode,
    output logic     o_in_stall,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_INIT  = 10'b00_0000_0010,
        ST_SW_RI = 10'b00_0000_0100,
        ST_SW_RC = 10'b00_0000_1000,
        ST_SW_WI = 10'b00_0001_0000,
        ST_SW_WC = 10'b00_0010_0000,
        ST_D_J   = 10'b00_0100_0000,
        ST_D_A   = 10'b00_1000_0000,
        ST_D_B   = 10'b01_0000_0000,
        ST_D_OUT = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_mode'(i_mode))
                        MODE_KEY:   o_cmd.key_wr = 1'b1;
                        MODE_RESET: o_cmd.clr    = 1'b1;
                        MODE_DATA: begin
                            o_cmd.data_cap = 1'b1;
                            if (i_stat.box_ready) begin
                                o_cmd.rd_j = 1'b1;
                                n_state    = ST_D_A;
                            end else begin
                                o_cmd.idx_clr = 1'b1;
                                n_state       = ST_INIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_stat.idx_last) begin
                    if (i_stat.key_empty) begin
                        o_cmd.set_ready = 1'b1;
                        n_state         = ST_D_J;
                    end else begin
                        n_state = ST_SW_RI;
                    end
                end
            end
            ST_SW_RI: begin
                o_cmd.sw_rd_i = 1'b1;
                n_state       = ST_SW_RC;
            end
            ST_SW_RC: begin
                o_cmd.sw_rd_c = 1'b1;
                n_state       = ST_SW_WI;
            end
            ST_SW_WI: begin
                o_cmd.sw_wr_i = 1'b1;
                n_state       = ST_SW_WC;
            end
            ST_SW_WC: begin
                o_cmd.sw_wr_c = 1'b1;
                if (i_stat.idx_last) begin
                    o_cmd.set_ready = 1'b1;
                    n_state         = ST_D_J;
                end else begin
                    n_state = ST_SW_RI;
                end
            end
            ST_D_J: begin
                o_cmd.rd_j = 1'b1;
                n_state    = ST_D_A;
            end
            ST_D_A: begin
                o_cmd.rd_ab = 1'b1;
                n_state     = ST_D_B;
            end
            ST_D_B: begin
                o_cmd.rd_mask = 1'b1;
                n_state       = ST_D_OUT;
            end
            ST_D_OUT: begin
                // hold the mask until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/core/rc4ks_dp.sv
`timescale 1ns / 1ps

module rc4ks_dp
    import rc4ks_pkg::*;
#(
    parameter int KEY_DEPTH = KEY_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BYTE_W-1:0] i_value,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_plain_byte
);

    localparam int CW = $clog2(KEY_DEPTH + 1);
    localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int AW = $clog2(BOX_DEPTH);

    logic [BYTE_W-1:0] box_mem [BOX_DEPTH];
    logic [BYTE_W-1:0] key_mem [KEY_DEPTH];

    logic [CW-1:0]     r_key_count;
    logic [AW-1:0]     r_pos;
    logic              r_box_ready;
    logic [AW-1:0]     r_idx;
    logic [KW-1:0]     r_k;
    logic [AW-1:0]     r_last;
    logic [AW-1:0]     r_c;
    logic [BYTE_W-1:0] r_held;
    logic [BYTE_W-1:0] r_a;
    logic [BYTE_W-1:0] r_data;
    logic [BYTE_W-1:0] r_box_rd;
    logic [BYTE_W-1:0] r_key_rd;
    logic [BYTE_W-1:0] r_plain;
    logic              r_out_valid;

    logic              key_room;
    logic              key_take;
    logic [AW-1:0]     j_idx;
    logic [AW-1:0]     c_now;
    logic              box_re;
    logic [AW-1:0]     box_raddr;
    logic              box_we;
    logic [AW-1:0]     box_waddr;
    logic [BYTE_W-1:0] box_wdata;
    logic [KW-1:0]     n_k;

    assign key_room = (r_key_count < CW'(KEY_DEPTH));
    assign key_take = i_cmd.key_wr && key_room;
    assign j_idx    = r_pos + AW'(1);
    assign c_now    = r_box_rd + r_last + r_key_rd;

    assign o_stat.key_empty = (r_key_count == '0);
    assign o_stat.box_ready = r_box_ready;
    assign o_stat.idx_last  = (r_idx == '1);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    assign box_re = i_cmd.sw_rd_i || i_cmd.sw_rd_c || i_cmd.rd_j
                 || i_cmd.rd_ab || i_cmd.rd_mask;
    assign box_we = i_cmd.init_wr || i_cmd.sw_wr_i || i_cmd.sw_wr_c;

    always_comb begin
        priority if (i_cmd.sw_rd_c) begin
            box_raddr = c_now;
        end else if (i_cmd.rd_j) begin
            box_raddr = j_idx;
        end else if (i_cmd.rd_ab) begin
            box_raddr = r_box_rd + j_idx;
        end else if (i_cmd.rd_mask) begin
            box_raddr = r_a + r_box_rd;
        end else begin
            box_raddr = r_idx;
        end
    end

    always_comb begin
        priority if (i_cmd.sw_wr_c) begin
            box_waddr = r_c;
            box_wdata = r_held;
        end else if (i_cmd.sw_wr_i) begin
            box_waddr = r_idx;
            box_wdata = r_box_rd;
        end else begin
            box_waddr = r_idx;
            box_wdata = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (box_we) begin
            box_mem[box_waddr] <= box_wdata;
        end
        if (box_re) begin
            r_box_rd <= box_mem[box_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_take) begin
            key_mem[r_key_count[KW-1:0]] <= i_value;
        end
        r_key_rd <= key_mem[r_k];
    end

    // wrap the key index back to the first byte after the last stored one
    assign n_k = ((CW'(r_k) + CW'(1)) >= r_key_count) ? '0 : r_k + KW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_clr) begin
            r_idx  <= '0;
            r_last <= '0;
            r_k    <= '0;
        end else begin
            if (i_cmd.init_wr || i_cmd.sw_wr_c) begin
                r_idx <= r_idx + AW'(1);
            end
            if (i_cmd.sw_wr_c) begin
                r_last <= r_c;
                r_k    <= n_k;
            end
        end
        if (i_cmd.sw_rd_c) begin
            r_c    <= c_now;
            r_held <= r_box_rd;
        end
        if (i_cmd.rd_ab) begin
            r_a <= r_box_rd;
        end
        if (i_cmd.data_cap) begin
            r_data <= i_value;
        end
        if (i_cmd.out_load) begin
            r_plain <= r_data ^ r_box_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
            r_pos       <= '0;
            r_box_ready <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_key_count <= '0;
                r_pos       <= '0;
                r_box_ready <= 1'b0;
            end else begin
                if (key_take) begin
                    r_key_count <= r_key_count + CW'(1);
                    r_box_ready <= 1'b0;
                end else if (i_cmd.set_ready) begin
                    r_box_ready <= 1'b1;
                end
                if (i_cmd.out_load) begin
                    r_pos <= r_pos + AW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_plain_byte = r_plain;

endmodule

>>> rtl/core/rc4_variant_keystream_xor_unit.sv
`timescale 1ns / 1ps
// Keystream XOR unit with a key-scheduled, static 256-entry permutation box.
// Input channel (i_in_valid / o_in_stall) carries a request of i_mode and
// i_value: MODE_KEY appends a key byte, MODE_DATA decrypts one byte,
// MODE_RESET clears the key and the stream position, code 3 is dropped.
// Key, reset and unused requests give no result and leave the input free.
// A data request gives one o_plain_byte on the output channel
// (o_out_valid / i_out_stall). With the box built, a data request makes
// three dependent reads through the one read port of the box memory
// plus the output load, and the input stays stalled until that load, so
// no new request is taken meanwhile. The first data request after a key
// change rebuilds the box: an identity fill of all 256 entries of the box
// memory, then 256 swaps, each a read at the index, a read at the new
// index and writes of both entries (one read and one write port), and a
// restart of the first read; with an empty key the swaps are skipped.
// The output register holds a result while the receiver stalls; the next
// request is accepted meanwhile, and its result waits in the last step.
// After reset the key is empty, the position is zero and the box is
// marked stale, so the first data request builds it.
module rc4_variant_keystream_xor_unit
    import rc4ks_pkg::*;
#(
    parameter int KEY_DEPTH = KEY_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_mode,
    input  logic [BYTE_W-1:0] i_value,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_plain_byte
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rc4ks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    rc4ks_dp #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_value),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_plain_byte (o_plain_byte)
    );

endmodule

>>> rtl/core/rc4ks_chk.sv
`timescale 1ns / 1ps

module rc4ks_chk
    import rc4ks_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [1:0]        i_mode,
    input logic [BYTE_W-1:0] i_value,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [BYTE_W-1:0] o_plain_byte
);

    logic in_acc;
    logic data_acc;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign data_acc = in_acc && (i_mode == MODE_DATA);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_plain_byte))
        else $error("result dropped or changed while stalled");

    a_data_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        data_acc |=> o_in_stall)
        else $error("data request did not block the input");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(o_out_valid))
        else $error("result appeared right after a request");

    a_key_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_mode != MODE_DATA) |=> !o_in_stall)
        else $error("non-data request blocked the input");

endmodule

bind rc4_variant_keystream_xor_unit rc4ks_chk u_rc4ks_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_mode       (i_mode),
    .i_value      (i_value),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_plain_byte (o_plain_byte)
);
